// ----- sv/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

  // width of the window length register
  localparam int unsigned CFG_WIDTH = 7;

  // controller to datapath
  typedef struct packed {
    logic wr;          // store accepted sample, advance write slot
    logic rd_cand;     // read candidate slot
    logic cand_next;   // step candidate slot to the next older sample
    logic cand_cap;    // latch candidate value from read data
    logic sweep_start; // rewind sweep slot, clear counts
    logic sweep_rd;    // read sweep slot and step it
    logic out_load;    // load result register
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic win_ready;   // window is full once the pending sample is stored
    logic sweep_done;  // all window slots have been read for this candidate
    logic found;       // candidate holds the median rank
    logic out_busy;    // result register still holds an untaken result
  } swm_stat_t;

endpackage

`default_nettype wire

// ----- sv/swm_ctrl.sv -----
`default_nettype none

module swm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output swm_pkg::swm_cmd_t      cmd,
  input  wire swm_pkg::swm_stat_t stat
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CAND,
    S_LD_CAND,
    S_SWEEP,
    S_CHECK
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.wr = 1'b1;
          if (stat.win_ready) begin
            state_nxt = S_RD_CAND;
          end
        end
      end
      S_RD_CAND: begin
        cmd.rd_cand     = 1'b1;
        cmd.sweep_start = 1'b1;
        state_nxt       = S_LD_CAND;
      end
      S_LD_CAND: begin
        cmd.cand_cap = 1'b1;
        cmd.sweep_rd = 1'b1;
        state_nxt    = S_SWEEP;
      end
      S_SWEEP: begin
        if (stat.sweep_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.sweep_rd = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.found) begin
          if (!stat.out_busy) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.cand_next = 1'b1;
          state_nxt     = S_RD_CAND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/swm_dp.sv -----
`default_nettype none

module swm_dp #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [swm_pkg::CFG_WIDTH-1:0]     cfg_wr_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [SAMPLE_WIDTH-1:0]           sample,
  output logic [SAMPLE_WIDTH-1:0]                median,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire swm_pkg::swm_cmd_t                 cmd,
  output swm_pkg::swm_stat_t                     stat
);
  import swm_pkg::*;

  localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW = $clog2(MAX_WINDOW + 1);

  logic [SAMPLE_WIDTH-1:0]        mem [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] rdata_r;
  logic signed [SAMPLE_WIDTH-1:0] cand_val_r;
  logic [SAMPLE_WIDTH-1:0]        out_data_r;
  logic                           out_vld_r;
  logic                           cmp_vld_r;

  logic [CFG_WIDTH-1:0] cfg_r;
  logic [PW-1:0]        wp_r;
  logic [LW-1:0]        fill_r;
  logic [PW-1:0]        cand_slot_r;
  logic [PW-1:0]        sweep_slot_r;
  logic [LW-1:0]        sweep_cnt_r;
  logic [LW-1:0]        less_r;
  logic [LW-1:0]        le_r;

  logic [LW-1:0] eff_len;
  logic [LW-1:0] rank;
  logic [LW-1:0] fill_inc;
  logic [PW-1:0] rd_addr;
  logic          lt;
  logic          le;

  function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] s);
    return (s == '0) ? PW'(MAX_WINDOW - 1) : s - 1'b1;
  endfunction

  // clamp the programmed length into 1..MAX_WINDOW
  always_comb begin
    if (cfg_r == '0) begin
      eff_len = LW'(1);
    end else if (int'(cfg_r) > MAX_WINDOW) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(cfg_r);
    end
  end

  assign rank     = (eff_len - 1'b1) >> 1;
  assign fill_inc = (fill_r == LW'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
  assign rd_addr  = cmd.rd_cand ? cand_slot_r : sweep_slot_r;
  assign lt       = rdata_r < cand_val_r;
  assign le       = rdata_r <= cand_val_r;

  assign stat.win_ready  = fill_inc >= eff_len;
  assign stat.sweep_done = sweep_cnt_r == eff_len;
  assign stat.found      = (less_r <= rank) && (rank < le_r);
  assign stat.out_busy   = out_vld_r && !out_tready;

  assign median     = out_data_r;
  assign out_tvalid = out_vld_r;

  // sample ring, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wp_r] <= sample;
    end
    if (cmd.rd_cand || cmd.sweep_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_WIDTH'(1);
      wp_r      <= '0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (cmd.wr) begin
        wp_r   <= (wp_r == PW'(MAX_WINDOW - 1)) ? '0 : wp_r + 1'b1;
        fill_r <= fill_inc;
      end
      cmp_vld_r <= cmd.sweep_rd;
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      cand_slot_r <= wp_r;
    end else if (cmd.cand_next) begin
      cand_slot_r <= slot_dec(cand_slot_r);
    end
    if (cmd.cand_cap) begin
      cand_val_r <= rdata_r;
    end
    if (cmd.sweep_start) begin
      sweep_slot_r <= wp_r == '0 ? PW'(MAX_WINDOW - 1) : wp_r - 1'b1;
      sweep_cnt_r  <= '0;
      less_r       <= '0;
      le_r         <= '0;
    end else begin
      if (cmd.sweep_rd) begin
        sweep_slot_r <= slot_dec(sweep_slot_r);
        sweep_cnt_r  <= sweep_cnt_r + 1'b1;
      end
      if (cmp_vld_r) begin
        less_r <= less_r + LW'(lt);
        le_r   <= le_r + LW'(le);
      end
    end
    if (cmd.out_load) begin
      out_data_r <= cand_val_r;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sliding_window_median_core.sv -----
`default_nettype none

// channel  | direction | ports                       | content
// ---------+-----------+-----------------------------+---------------------------------
// in       | slave     | in_tvalid/in_tready/in_tdata | sample, signed
// out      | master    | out_tvalid/out_tready/out_tdata | median, signed (lower median)
// cfg      | write     | cfg_wr_en/cfg_wr_data        | window_length, 1..MAX_WINDOW
//
// a transaction needs no search while the window is not yet full; otherwise
// candidates are tried newest first, each read, loaded, swept against all L
// slots (L the window length) and checked, until the k-th (1..L) holds the
// median rank; with the single ring read port, one sample is compared per cycle
// reset (rst_n low, synchronous) empties the window and sets the length to 1
// a result waiting in the output register does not block the next sample;
// the search only stalls at its end if that register is still occupied

module sliding_window_median_core #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // configuration
  input  wire logic                                      cfg_wr_en,
  input  wire logic [swm_pkg::CFG_WIDTH-1:0]             cfg_wr_data,  // window_length
  // input stream
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,     // sample
  // result stream
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]      out_tdata     // median
);
  import swm_pkg::*;

  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  swm_cmd_t                cmd;
  swm_stat_t               stat;
  logic [SAMPLE_WIDTH-1:0] median;

  // sequencer: accept, candidate loop, sweep loop, result hand-off
  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // ring memory, pointers, rank counters and result register
  swm_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_data (cfg_wr_data),
    .cfg_wr_en   (cfg_wr_en),
    .sample      (in_tdata[SAMPLE_WIDTH-1:0]),
    .median      (median),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // zero padding up to whole bytes
  assign out_tdata = DW'(median);

endmodule

`default_nettype wire
